/* rtl/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg: shared constants for the segment distance pipeline
// Fraction width of the clamped line parameters, output format and the
// chunk size used by the pipelined multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

    // fraction bits of the closest-point parameters sc and tc
    localparam int T_BITS = 48;

    // output distance, unsigned Q25.0 (integer)
    localparam int DIST_W = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // multiplier operand B is consumed this many bits per stage
    localparam int MUL_CHUNK = 16;

    // latency in cycles of ssd_mul for a B operand of wb bits
    function automatic int mul_lat(input int wb);
        return (wb + MUL_CHUNK - 1) / MUL_CHUNK + 1;
    endfunction

endpackage

`default_nettype wire

/* rtl/ssd_mul.sv */
// ----------------------------------------------------------------------------
// ssd_mul: pipelined signed multiplier
// Operand B is split into MUL_CHUNK-bit digits; each stage adds one
// partial product A*digit into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [WA-1:0]  i_a,
    input  wire logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0]   o_p
);

    localparam int CH  = ssd_pkg::MUL_CHUNK;
    localparam int NCH = (WB + CH - 1) / CH;
    localparam int WBX = NCH * CH;
    localparam int WP  = WA + WB;

    logic signed [WA-1:0]  r_a   [0:NCH-1];
    logic signed [WB-1:0]  r_b   [0:NCH-1];
    logic signed [WP-1:0]  r_acc [1:NCH];

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0] <= i_a;
            r_b[0] <= i_b;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NCH; k++) begin : g_stage
            logic signed [WBX-1:0] w_bx;
            logic signed [WP-1:0]  w_dig;
            logic signed [WP-1:0]  w_pp;

            assign w_bx = WBX'(r_b[k]);

            // low digits are unsigned, the top digit carries the sign
            if (k == NCH - 1) begin : g_top
                assign w_dig = WP'($signed(w_bx[k*CH +: CH]));
            end else begin : g_low
                assign w_dig = $signed(WP'({1'b0, w_bx[k*CH +: CH]}));
            end

            assign w_pp = (WP'(r_a[k]) * w_dig) <<< (k * CH);

            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_acc[1] <= w_pp;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_acc[k+1] <= r_acc[k] + w_pp;
                    end
                end
            end

            if (k < NCH - 1) begin : g_fwd
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_a[k+1] <= r_a[k];
                        r_b[k+1] <= r_b[k];
                    end
                end
            end
        end
    endgenerate

    assign o_p = r_acc[NCH];

endmodule

`default_nettype wire

/* rtl/ssd_div.sv */
// ----------------------------------------------------------------------------
// ssd_div: pipelined restoring fraction divider
// Gives floor(num * 2^(QB-1) / den) for 0 <= num <= den, den > 0,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_div #(
    parameter int W  = 32,
    parameter int QB = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    output logic [QB-1:0]      o_q
);

    logic [W-1:0]  r_rem [0:QB-2];
    logic [W-1:0]  r_den [0:QB-2];
    logic [QB-1:0] r_q   [0:QB-1];

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_stage
            logic [W:0]    w_rem_in;
            logic [W-1:0]  w_den_in;
            logic [QB-1:0] w_q_in;
            logic          w_ge;
            logic [W:0]    w_rem_out;

            if (j == 0) begin : g_first
                assign w_rem_in = {1'b0, i_num};
                assign w_den_in = i_den;
                assign w_q_in   = '0;
            end else begin : g_next
                assign w_rem_in = {r_rem[j-1], 1'b0};
                assign w_den_in = r_den[j-1];
                assign w_q_in   = r_q[j-1];
            end

            // trial subtract
            assign w_ge      = (w_rem_in >= {1'b0, w_den_in});
            assign w_rem_out = w_ge ? (w_rem_in - {1'b0, w_den_in}) : w_rem_in;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[j] <= w_q_in | (QB'(w_ge) << (QB - 1 - j));
                end
            end

            // remainder and divisor feed the next stage only
            if (j < QB - 1) begin : g_fwd
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j] <= w_rem_out[W-1:0];
                        r_den[j] <= w_den_in;
                    end
                end
            end
        end
    endgenerate

    assign o_q = r_q[QB-1];

endmodule

`default_nettype wire

/* rtl/segment_segment_distance.sv */
// ----------------------------------------------------------------------------
// segment_segment_distance: shortest distance between two 3D segments
// Fully pipelined; stall freezes every stage.
// ----------------------------------------------------------------------------
// Takes one word per cycle while o_stall is low and returns one distance word
// per input word, in order. The bulk of the pipe is the 49-stage fraction
// dividers and the one-bit-per-stage square root. The whole pipe advances
// unless a finished distance is held by i_stall, so o_stall is just that.
`default_nettype none

module segment_segment_distance #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_BITS-1:0]  i_a_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_a_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_a_start_z,
    input  wire logic signed [COORD_BITS-1:0]  i_a_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_a_end_y,
    input  wire logic signed [COORD_BITS-1:0]  i_a_end_z,
    input  wire logic signed [COORD_BITS-1:0]  i_b_start_x,
    input  wire logic signed [COORD_BITS-1:0]  i_b_start_y,
    input  wire logic signed [COORD_BITS-1:0]  i_b_start_z,
    input  wire logic signed [COORD_BITS-1:0]  i_b_end_x,
    input  wire logic signed [COORD_BITS-1:0]  i_b_end_y,
    input  wire logic signed [COORD_BITS-1:0]  i_b_end_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ssd_pkg::DIST_W-1:0]         o_distance
);

    localparam int T    = ssd_pkg::T_BITS;
    localparam int QB   = T + 1;
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int MW   = 2 * DOTW;
    localparam int NW   = MW + 1;
    localparam int PPW  = DW + T + 2;
    localparam int SQW  = 2 * PPW + 2;
    localparam int SHW  = SQW - 2 * T;
    localparam int RB   = (SHW + 1) / 2;
    localparam int TW   = 2 * RB + 1;
    localparam int EW   = (RB > ssd_pkg::DIST_W) ? RB : ssd_pkg::DIST_W;
    localparam int LM1  = ssd_pkg::mul_lat(DOTW);
    localparam int LM2  = ssd_pkg::mul_lat(QB + 1);
    localparam int LM3  = ssd_pkg::mul_lat(PPW);

    // cycle at which each stage's register holds an item
    localparam int E_S1   = 1;
    localparam int E_S3   = 3;
    localparam int E_MUL1 = E_S3 + LM1;
    localparam int E_D    = E_MUL1 + 1;
    localparam int E_CA   = E_D + 1;
    localparam int E_CB   = E_CA + 1;
    localparam int E_DIV  = E_CB + QB;
    localparam int E_MUL2 = E_DIV + LM2;
    localparam int E_P    = E_MUL2 + 1;
    localparam int E_SQ   = E_P + LM3;
    localparam int E_SUM  = E_SQ + 1;
    localparam int E_RT   = E_SUM + RB;
    localparam int NST    = E_RT + 1;
    localparam int DUV    = E_DIV - E_S1;

    // dot product slots
    localparam int IX_A = 0;
    localparam int IX_B = 1;
    localparam int IX_C = 2;
    localparam int IX_D = 3;
    localparam int IX_E = 4;

    logic w_adv;
    logic [1:NST] r_vld;

    // ---------------- pipeline control ----------------
    assign w_adv   = !(r_vld[NST] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {i_valid, r_vld[1:NST-1]};
        end
    end

    // ---------------- stage 1: direction and offset vectors ----------------
    logic signed [COORD_BITS-1:0] w_as [0:2];
    logic signed [COORD_BITS-1:0] w_ae [0:2];
    logic signed [COORD_BITS-1:0] w_bs [0:2];
    logic signed [COORD_BITS-1:0] w_be [0:2];
    logic signed [DW-1:0] r1_u [0:2];
    logic signed [DW-1:0] r1_v [0:2];
    logic signed [DW-1:0] r1_w [0:2];

    assign w_as = '{i_a_start_x, i_a_start_y, i_a_start_z};
    assign w_ae = '{i_a_end_x, i_a_end_y, i_a_end_z};
    assign w_bs = '{i_b_start_x, i_b_start_y, i_b_start_z};
    assign w_be = '{i_b_end_x, i_b_end_y, i_b_end_z};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_u[i] <= DW'(w_ae[i]) - DW'(w_as[i]);
                r1_v[i] <= DW'(w_be[i]) - DW'(w_bs[i]);
                r1_w[i] <= DW'(w_as[i]) - DW'(w_bs[i]);
            end
        end
    end

    // ---------------- stage 2: component products ----------------
    logic signed [PW-1:0] r2_uu [0:2];
    logic signed [PW-1:0] r2_uv [0:2];
    logic signed [PW-1:0] r2_vv [0:2];
    logic signed [PW-1:0] r2_uw [0:2];
    logic signed [PW-1:0] r2_vw [0:2];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_uu[i] <= PW'(r1_u[i]) * PW'(r1_u[i]);
                r2_uv[i] <= PW'(r1_u[i]) * PW'(r1_v[i]);
                r2_vv[i] <= PW'(r1_v[i]) * PW'(r1_v[i]);
                r2_uw[i] <= PW'(r1_u[i]) * PW'(r1_w[i]);
                r2_vw[i] <= PW'(r1_v[i]) * PW'(r1_w[i]);
            end
        end
    end

    // ---------------- stage 3: dot products a..e ----------------
    logic signed [DOTW-1:0] r3_dot [0:4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_dot[IX_A] <= DOTW'(r2_uu[0]) + DOTW'(r2_uu[1]) + DOTW'(r2_uu[2]);
            r3_dot[IX_B] <= DOTW'(r2_uv[0]) + DOTW'(r2_uv[1]) + DOTW'(r2_uv[2]);
            r3_dot[IX_C] <= DOTW'(r2_vv[0]) + DOTW'(r2_vv[1]) + DOTW'(r2_vv[2]);
            r3_dot[IX_D] <= DOTW'(r2_uw[0]) + DOTW'(r2_uw[1]) + DOTW'(r2_uw[2]);
            r3_dot[IX_E] <= DOTW'(r2_vw[0]) + DOTW'(r2_vw[1]) + DOTW'(r2_vw[2]);
        end
    end

    // ---------------- dot products of dot products ----------------
    logic signed [MW-1:0] w_ac, w_bb, w_be2, w_cd, w_ae2, w_bd;

    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ac (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_A]), .i_b(r3_dot[IX_C]), .o_p(w_ac)
    );
    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bb (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_B]), .i_b(r3_dot[IX_B]), .o_p(w_bb)
    );
    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_be (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_B]), .i_b(r3_dot[IX_E]), .o_p(w_be2)
    );
    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_cd (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_C]), .i_b(r3_dot[IX_D]), .o_p(w_cd)
    );
    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ae (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_A]), .i_b(r3_dot[IX_E]), .o_p(w_ae2)
    );
    ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bd (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r3_dot[IX_B]), .i_b(r3_dot[IX_D]), .o_p(w_bd)
    );

    // dot products ride along the multipliers
    logic signed [DOTW-1:0] r_dot_d [0:LM1-1][0:4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dot_d[0] <= r3_dot;
            for (int k = 1; k < LM1; k++) begin
                r_dot_d[k] <= r_dot_d[k-1];
            end
        end
    end

    // ---------------- determinant and raw numerators ----------------
    logic signed [NW-1:0]   r_det, r_sn0, r_tn0;
    logic signed [DOTW-1:0] r4_dot [0:4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_det  <= NW'(w_ac) - NW'(w_bb);
            r_sn0  <= NW'(w_be2) - NW'(w_cd);
            r_tn0  <= NW'(w_ae2) - NW'(w_bd);
            r4_dot <= r_dot_d[LM1-1];
        end
    end

    // ---------------- clamp, first pass: parallel case and s range ----------------
    logic signed [NW-1:0] n_ca_sn, n_ca_sd, n_ca_tn, n_ca_td;
    logic signed [NW-1:0] r_ca_sn, r_ca_sd, r_ca_tn, r_ca_td;
    logic signed [NW-1:0] r_ca_a, r_ca_b, r_ca_d;

    always_comb begin
        logic signed [NW-1:0] v_c, v_e, v_b;
        v_b = NW'(r4_dot[IX_B]);
        v_c = NW'(r4_dot[IX_C]);
        v_e = NW'(r4_dot[IX_E]);
        priority if (r_det <= 0) begin
            n_ca_sn = '0;
            n_ca_sd = NW'(1);
            n_ca_tn = v_e;
            n_ca_td = v_c;
        end else if (r_sn0 < 0) begin
            n_ca_sn = '0;
            n_ca_sd = r_det;
            n_ca_tn = v_e;
            n_ca_td = v_c;
        end else if (r_sn0 > r_det) begin
            n_ca_sn = r_det;
            n_ca_sd = r_det;
            n_ca_tn = v_e + v_b;
            n_ca_td = v_c;
        end else begin
            n_ca_sn = r_sn0;
            n_ca_sd = r_det;
            n_ca_tn = r_tn0;
            n_ca_td = r_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ca_sn <= n_ca_sn;
            r_ca_sd <= n_ca_sd;
            r_ca_tn <= n_ca_tn;
            r_ca_td <= n_ca_td;
            r_ca_a  <= NW'(r4_dot[IX_A]);
            r_ca_b  <= NW'(r4_dot[IX_B]);
            r_ca_d  <= NW'(r4_dot[IX_D]);
        end
    end

    // ---------------- clamp, second pass: t range, s recomputed ----------------
    logic [MW-1:0] n_snum, n_sden, n_tnum, n_tden;
    logic [MW-1:0] r_snum, r_sden, r_tnum, r_tden;

    always_comb begin
        logic signed [NW-1:0] v_sn, v_sd, v_tn, v_td, v_alt;
        v_sn = r_ca_sn;
        v_sd = r_ca_sd;
        v_tn = r_ca_tn;
        v_td = r_ca_td;
        // candidate s numerator when t sticks to an end
        v_alt = (r_ca_tn < 0) ? -r_ca_d : (r_ca_b - r_ca_d);
        if (r_ca_tn < 0 || r_ca_tn > r_ca_td) begin
            v_tn = (r_ca_tn < 0) ? '0 : r_ca_td;
            priority if (v_alt < 0) begin
                v_sn = '0;
            end else if (v_alt > r_ca_a) begin
                v_sn = r_ca_sd;
            end else begin
                v_sn = v_alt;
                v_sd = r_ca_a;
            end
        end
        // non-positive numerators become 0; a non-positive denominator gives 0/1
        n_snum = (v_sn > 0 && v_sd > 0) ? v_sn[MW-1:0] : '0;
        n_sden = (v_sd > 0) ? v_sd[MW-1:0] : MW'(1);
        n_tnum = (v_tn > 0 && v_td > 0) ? v_tn[MW-1:0] : '0;
        n_tden = (v_td > 0) ? v_td[MW-1:0] : MW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_snum <= n_snum;
            r_sden <= n_sden;
            r_tnum <= n_tnum;
            r_tden <= n_tden;
        end
    end

    // ---------------- fraction dividers ----------------
    logic [QB-1:0] w_sc, w_tc;

    ssd_div #(.W(MW), .QB(QB)) u_div_s (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_snum), .i_den(r_sden), .o_q(w_sc)
    );
    ssd_div #(.W(MW), .QB(QB)) u_div_t (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_tnum), .i_den(r_tden), .o_q(w_tc)
    );

    // u, v, w wait for the fractions
    logic signed [DW-1:0] r_ud [0:DUV-1][0:2];
    logic signed [DW-1:0] r_vd [0:DUV-1][0:2];
    logic signed [DW-1:0] r_wd [0:DUV-1][0:2];
    logic signed [DW-1:0] r_wd2 [0:LM2-1][0:2];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ud[0] <= r1_u;
            r_vd[0] <= r1_v;
            r_wd[0] <= r1_w;
            for (int k = 1; k < DUV; k++) begin
                r_ud[k] <= r_ud[k-1];
                r_vd[k] <= r_vd[k-1];
                r_wd[k] <= r_wd[k-1];
            end
            r_wd2[0] <= r_wd[DUV-1];
            for (int k = 1; k < LM2; k++) begin
                r_wd2[k] <= r_wd2[k-1];
            end
        end
    end

    // ---------------- closest-point difference ----------------
    logic signed [QB:0]    w_scs, w_tcs;
    logic signed [PPW-1:0] w_us [0:2];
    logic signed [PPW-1:0] w_vt [0:2];
    logic signed [PPW-1:0] r_p  [0:2];

    assign w_scs = $signed({1'b0, w_sc});
    assign w_tcs = $signed({1'b0, w_tc});

    genvar ax;
    generate
        for (ax = 0; ax < 3; ax++) begin : g_axis
            ssd_mul #(.WA(DW), .WB(QB + 1)) u_mul_us (
                .i_clk(i_clk), .i_en(w_adv), .i_a(r_ud[DUV-1][ax]), .i_b(w_scs),
                .o_p(w_us[ax])
            );
            ssd_mul #(.WA(DW), .WB(QB + 1)) u_mul_vt (
                .i_clk(i_clk), .i_en(w_adv), .i_a(r_vd[DUV-1][ax]), .i_b(w_tcs),
                .o_p(w_vt[ax])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= (PPW'(r_wd2[LM2-1][i]) <<< T) + w_us[i] - w_vt[i];
            end
        end
    end

    // ---------------- squared length ----------------
    logic signed [2*PPW-1:0] w_sq [0:2];
    logic [SHW-1:0] r_sh;
    logic [SQW-1:0] w_sum;

    generate
        for (ax = 0; ax < 3; ax++) begin : g_sq
            ssd_mul #(.WA(PPW), .WB(PPW)) u_mul_sq (
                .i_clk(i_clk), .i_en(w_adv), .i_a(r_p[ax]), .i_b(r_p[ax]), .o_p(w_sq[ax])
            );
        end
    endgenerate

    // squares are never negative
    assign w_sum = SQW'(unsigned'(w_sq[0])) + SQW'(unsigned'(w_sq[1]))
                 + SQW'(unsigned'(w_sq[2]));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sh <= w_sum[SQW-1:2*T];
        end
    end

    // ---------------- integer square root, one bit per stage ----------------
    logic [SHW-1:0] r_rt_rem  [0:RB-1];
    logic [RB-1:0]  r_rt_root [0:RB-1];

    genvar j;
    generate
        for (j = 0; j < RB; j++) begin : g_root
            localparam int BI = RB - 1 - j;
            logic [SHW-1:0] w_rem_in;
            logic [RB-1:0]  w_root_in;
            logic [TW-1:0]  w_test;
            logic           w_ge;

            if (j == 0) begin : g_first
                assign w_rem_in  = r_sh;
                assign w_root_in = '0;
            end else begin : g_next
                assign w_rem_in  = r_rt_rem[j-1];
                assign w_root_in = r_rt_root[j-1];
            end

            // (root + 2^BI)^2 - root^2
            assign w_test = (TW'(w_root_in) << (BI + 1)) + (TW'(1) << (2 * BI));
            assign w_ge   = (TW'(w_rem_in) >= w_test);

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rt_rem[j]  <= w_ge ? SHW'(TW'(w_rem_in) - w_test) : w_rem_in;
                    r_rt_root[j] <= w_root_in | (RB'(w_ge) << BI);
                end
            end
        end
    endgenerate

    // ---------------- saturate and output register ----------------
    logic [EW-1:0] w_root_ext;
    logic [ssd_pkg::DIST_W-1:0] r_out;

    assign w_root_ext = EW'(r_rt_root[RB-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= (w_root_ext > EW'(ssd_pkg::DIST_MAX)) ? ssd_pkg::DIST_MAX
                                                        : w_root_ext[ssd_pkg::DIST_W-1:0];
        end
    end

    assign o_distance = r_out;

    // ---------------- assertions ----------------
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output word was stalled");

    a_s_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[E_CB] |-> (r_snum <= r_sden && r_sden != '0))
        else $error("s fraction out of range at divider input");

    a_t_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[E_CB] |-> (r_tnum <= r_tden && r_tden != '0))
        else $error("t fraction out of range at divider input");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: segment_segment_distance regression bench
// Streams 3D segment pairs into the pipeline with random gaps and output
// back-pressure, predicts every distance with exact wide integer math and
// checks each returned word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    typedef logic signed [255:0] wide_t;
    typedef logic [11:0][23:0]   seg_pair_t;

    typedef struct {
        seg_pair_t pts;
        bit        drain_first;   // wait for an empty pipe before offering
    } pair_word_t;

    localparam int PIPE_LAT     = 102;
    localparam int RANDOM_PAIRS = 1400;
    localparam logic [24:0] DIST_SAT = ssd_pkg::DIST_MAX;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic signed [23:0]  pt_drv [12];
    logic                o_valid;
    logic                i_stall;
    logic [24:0]         o_distance;

    pair_word_t   pair_queue [$];
    logic [24:0]  dist_expected [$];
    int           errors;
    int           pairs_sent;
    int           dists_seen;
    int           parallel_cnt;

    segment_segment_distance dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_start_x (pt_drv[0]),
        .i_a_start_y (pt_drv[1]),
        .i_a_start_z (pt_drv[2]),
        .i_a_end_x   (pt_drv[3]),
        .i_a_end_y   (pt_drv[4]),
        .i_a_end_z   (pt_drv[5]),
        .i_b_start_x (pt_drv[6]),
        .i_b_start_y (pt_drv[7]),
        .i_b_start_z (pt_drv[8]),
        .i_b_end_x   (pt_drv[9]),
        .i_b_end_y   (pt_drv[10]),
        .i_b_end_z   (pt_drv[11]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_distance  (o_distance)
    );

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // fraction num/den with 48 fraction bits; zero when either side is not positive
    function automatic wide_t frac48(input wide_t num, input wide_t den);
        if (num <= 0 || den <= 0) return '0;
        return (num <<< 48) / den;
    endfunction

    // exact closest distance between the two segments, unsigned Q25.0 truncated
    function automatic logic [24:0] seg_distance(input seg_pair_t pts);
        wide_t u [3];
        wide_t v [3];
        wide_t w [3];
        wide_t uu, uv, vv, uw, vw, det, sn, sd, tn, td, alt, sc, tc, p, sum, sh, sq;
        logic [63:0] r, t;
        for (int i = 0; i < 3; i++) begin
            u[i] = wide_t'($signed(pts[3+i])) - wide_t'($signed(pts[i]));
            v[i] = wide_t'($signed(pts[9+i])) - wide_t'($signed(pts[6+i]));
            w[i] = wide_t'($signed(pts[i])) - wide_t'($signed(pts[6+i]));
        end
        uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        vw = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
        det = uu*vv - uv*uv;

        // parallel or degenerate: pin s at the start of A
        if (det <= 0) begin
            sn = 0; sd = 1; tn = vw; td = vv;
        end else begin
            sd = det; td = det;
            sn = uv*vw - vv*uw;
            tn = uu*vw - uv*uw;
            if (sn < 0) begin
                sn = 0; tn = vw; td = vv;
            end else if (sn > sd) begin
                sn = sd; tn = vw + uv; td = vv;
            end
        end

        // clamp t and redo s against the clamped end of B
        if (tn < 0) begin
            alt = -uw;
            tn = 0;
            if (alt < 0) sn = 0;
            else if (alt > uu) sn = sd;
            else begin
                sn = alt; sd = uu;
            end
        end else if (tn > td) begin
            alt = uv - uw;
            tn = td;
            if (alt < 0) sn = 0;
            else if (alt > uu) sn = sd;
            else begin
                sn = alt; sd = uu;
            end
        end

        sc = frac48(sn, sd);
        tc = frac48(tn, td);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            p = (w[i] <<< 48) + u[i]*sc - v[i]*tc;
            sum = sum + p*p;
        end
        sh = sum >>> 96;

        // bitwise integer square root
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            sq = wide_t'({192'd0, t}) * wide_t'({192'd0, t});
            if (sq <= sh) r = t;
        end
        if (r > 64'(DIST_SAT)) r = 64'(DIST_SAT);
        return r[24:0];
    endfunction

    function automatic logic [23:0] small_coord(input int span);
        return 24'($signed($urandom_range(0, 2*span)) - span);
    endfunction

    function automatic logic [23:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            4: return 24'h000001;
            default: return 24'($urandom);
        endcase
    endfunction

    // random pair; the shape decides which branch of the solver is hit
    function automatic seg_pair_t random_pair();
        seg_pair_t   pts;
        int          shape, k, span;
        logic [23:0] dir;
        shape = $urandom_range(0, 9);
        span  = ($urandom_range(0, 7) == 0) ? 4000000 : 3000;
        for (int i = 0; i < 12; i++)
            pts[i] = (shape <= 2) ? 24'($urandom) : small_coord(span);
        case (shape)
            // B parallel to A, scaled by a small whole factor
            3, 4: begin
                k = $urandom_range(0, 3);
                for (int i = 0; i < 3; i++) begin
                    dir = 24'($signed(pts[3+i]) - $signed(pts[i]));
                    case (k)
                        0: pts[9+i] = 24'($signed(pts[6+i]) + $signed(dir));
                        1: pts[9+i] = 24'($signed(pts[6+i]) - $signed(dir));
                        2: pts[9+i] = 24'($signed(pts[6+i]) + 2*$signed(dir));
                        default: pts[9+i] = 24'($signed(pts[6+i]) - 2*$signed(dir));
                    endcase
                end
            end
            // zero-length A, B or both
            5: begin
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) begin
                    if (k != 1) pts[3+i] = pts[i];
                    if (k != 0) pts[9+i] = pts[6+i];
                end
            end
            6: for (int i = 0; i < 12; i++) pts[i] = edge_coord();
            default: ;
        endcase
        return pts;
    endfunction

    function automatic seg_pair_t make_pair(input int ax, ay, az, bx, by, bz,
                                            input int cx, cy, cz, dx, dy, dz);
        seg_pair_t pts;
        pts[0] = 24'(ax); pts[1]  = 24'(ay); pts[2]  = 24'(az);
        pts[3] = 24'(bx); pts[4]  = 24'(by); pts[5]  = 24'(bz);
        pts[6] = 24'(cx); pts[7]  = 24'(cy); pts[8]  = 24'(cz);
        pts[9] = 24'(dx); pts[10] = 24'(dy); pts[11] = 24'(dz);
        return pts;
    endfunction

    task automatic push_pair(input seg_pair_t pts, input bit drain);
        pair_word_t wd;
        wd.pts = pts;
        wd.drain_first = drain;
        pair_queue.push_back(wd);
    endtask

    // stimulus: directed corners, then random pairs
    initial begin
        seg_pair_t pts;
        push_pair('0, 1'b0);
        push_pair({12{24'h7FFFFF}}, 1'b0);
        push_pair({12{24'h800000}}, 1'b0);
        // longest reach: opposite corners of the coordinate cube
        push_pair({{6{24'h7FFFFF}}, {6{24'h800000}}}, 1'b0);
        push_pair({{6{24'h800000}}, {6{24'h7FFFFF}}}, 1'b0);
        push_pair({{3{24'h800000}}, {3{24'h7FFFFF}}, {3{24'h7FFFFF}}, {3{24'h800000}}},
                  1'b0);
        // crossing in the interior
        push_pair(make_pair(-256, 0, 0, 256, 0, 0, 0, -256, 128, 0, 256, 128), 1'b0);
        // parallel, overlapping and disjoint
        push_pair(make_pair(0, 0, 0, 1024, 0, 0, 256, 300, 0, 768, 300, 0), 1'b0);
        push_pair(make_pair(0, 0, 0, 1024, 0, 0, 2048, 300, 0, 4096, 300, 0), 1'b0);
        push_pair(make_pair(0, 0, 0, 1024, 0, 0, -512, 0, 0, -2048, 0, 0), 1'b0);
        // zero-length A, zero-length B, both
        push_pair(make_pair(5, 6, 7, 5, 6, 7, 0, 0, 0, 900, 100, -40), 1'b0);
        push_pair(make_pair(-300, 20, 0, 700, 20, 9, 40, 40, 40, 40, 40, 40), 1'b0);
        push_pair(make_pair(1, 2, 3, 1, 2, 3, -700, 800, 900, -700, 800, 900), 1'b0);
        // s clamped below zero and above one
        push_pair(make_pair(1000, 0, 0, 2000, 0, 0, 0, -500, 100, 0, 500, 100), 1'b0);
        push_pair(make_pair(-2000, 0, 0, -1000, 0, 0, 0, -500, 100, 0, 500, 100), 1'b0);
        // t clamped below zero and above one
        push_pair(make_pair(-500, 0, 0, 500, 0, 0, 0, 1000, 50, 0, 2000, 50), 1'b0);
        push_pair(make_pair(-500, 0, 0, 500, 0, 0, 0, -2000, 50, 0, -1000, 50), 1'b0);
        // both clamped at corners
        push_pair(make_pair(0, 0, 0, 100, 0, 0, 300, 300, 300, 300, 900, 300), 1'b0);
        push_pair(make_pair(0, 0, 0, -100, -100, 0, 500, 600, -700, 900, 900, -900), 1'b0);
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            pts = random_pair();
            push_pair(pts, (n == RANDOM_PAIRS/2) || (n == 3*RANDOM_PAIRS/4));
        end
    end

    // sender: offers queued pairs, random gaps, pauses to drain when flagged
    int gap_left;
    initial gap_left = 0;
    always @(posedge i_clk) begin
        pair_word_t nxt;
        logic       next_valid;
        logic       busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                dist_expected.push_back(seg_distance(pair_queue[0].pts));
                pair_queue.pop_front();
                pairs_sent++;
                if ($urandom_range(0, 2) == 0)
                    gap_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(1, 3);
            end
            next_valid = busy;
            if (!busy && pair_queue.size() > 0) begin
                nxt = pair_queue[0];
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!nxt.drain_first || dist_expected.size() == 0) begin
                    pair_queue[0].drain_first = 1'b0;
                    for (int i = 0; i < 12; i++) pt_drv[i] <= nxt.pts[i];
                    next_valid = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    // receiver: random stalls, one long hold-off, in-order check
    int stall_left;
    bit long_hold_done;
    initial begin
        stall_left = 0;
        long_hold_done = 0;
        errors = 0;
        pairs_sent = 0;
        dists_seen = 0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        for (int i = 0; i < 12; i++) pt_drv[i] = '0;
    end

    always @(posedge i_clk) begin
        logic [24:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                dists_seen++;
                if (dist_expected.size() == 0) begin
                    $error("unexpected distance word %0d", o_distance);
                    errors++;
                end else begin
                    want = dist_expected.pop_front();
                    if (o_distance !== want) begin
                        $error("distance: expected %0d, got %0d", want, o_distance);
                        errors++;
                    end
                end
            end
            if (!long_hold_done && pairs_sent >= 300) begin
                long_hold_done = 1;
                stall_left = 400;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(1, 3);
            end else if (stall_left == 0 && $urandom_range(0, 50) == 0) begin
                // calm stretch with no stalls is the default case
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // end of test
    initial begin
        @(posedge i_rst_n);
        repeat (50) @(posedge i_clk);
        while (pair_queue.size() > 0 || i_valid || dist_expected.size() > 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (dist_expected.size() != 0) begin
            $error("%0d distances never returned", dist_expected.size());
            errors++;
        end
        $display("segment pairs sent: %0d, distances checked: %0d, mismatches: %0d",
                 pairs_sent, dists_seen, errors);
        $display("covered corners, parallel, zero-length and clamped cases under stalls");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/ssd_pkg.sv
rtl/ssd_mul.sv
rtl/ssd_div.sv
rtl/segment_segment_distance.sv
sim/tb.sv
